### sv/frt_pkg.sv
package frt_pkg;

   localparam int NUM_ENTRIES_DEFAULT = 16;
   localparam int MAX_FRAGMENTS       = 16;
   localparam int CHUNK_MAX           = 1024;

   localparam int ID_W     = 16;
   localparam int SEQ_W    = 4;
   localparam int LEN_W    = 11;
   localparam int TIME_W   = 32;
   localparam int TMO_W    = 16;
   localparam int SLOT_W   = 4;
   localparam int OFFSET_W = 14;
   localparam int TOTAL_W  = 15;
   localparam int CSR_W    = 16;

   typedef enum logic [2:0] {
      STATUS_DROP     = 3'd0,
      STATUS_REJECT   = 3'd1,
      STATUS_ACCEPT   = 3'd2,
      STATUS_COMPLETE = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef enum logic {
      CSR_CHUNK_LEN = 1'b0,
      CSR_TIMEOUT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ID_W-1:0]          packet_id;
      logic [SEQ_W-1:0]         last_index;
      logic [MAX_FRAGMENTS-1:0] mask;
      logic [TIME_W-1:0]        stamp;
      logic [TOTAL_W-1:0]       total_len;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] op_a;
      logic [TIME_W-1:0] op_b;
      logic [TMO_W-1:0]  op_c;
   } cmp_req_type;

   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_rsp_type;

endpackage

### sv/fragment_reassembly_tracker.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   req_tdata: one fragment header
// rsp      out        rsp_tvalid / rsp_tready   rsp_tuser status, rsp_tdata result
// csr      in         csr_we (always taken)     csr_addr, csr_wdata
//
// One fragment goes through a serial lookup, then a serial timeout sweep, one
// entry a cycle through the shared compare unit and the registered table read,
// and the result goes to rsp after the sweep. A length drop skips both scans.
// reset is synchronous; it clears all entry valid bits and the control flags.
// The next transfer is taken while a result still waits on rsp; the one after
// that waits in RESP until rsp_tready frees the output register.
module fragment_reassembly_tracker
   import frt_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] packet_id, [19:16] frag_seq, [23:20] last_index,
   // [34:24] payload_len, [66:35] now_seconds, [71:67] zero
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] slot, [17:4] write_offset, [32:18] total_len, [39:33] zero
   output logic [39:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_SWEEP  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0] chunk_len_ff, chunk_len_in;
   logic [TMO_W-1:0] timeout_ff, timeout_in;
   logic [LEN_W-1:0] chunk_eff;

   logic [ID_W-1:0]   id_ff, id_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [SEQ_W-1:0]  last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;

   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        hit_entry_ff, hit_entry_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   status_type          res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic [TOTAL_W-1:0]  res_total_ff, res_total_in;

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_addr;
   entry_type        tbl_wr_data;
   logic [IDX_W-1:0] tbl_rd_addr;
   entry_type        tbl_rd_data;

   cmp_req_type cmp_req;
   cmp_rsp_type cmp_rsp;

   logic                     scan_done;
   logic                     bad_frag;
   logic                     conflict;
   logic [MAX_FRAGMENTS-1:0] new_mask;
   logic [MAX_FRAGMENTS-1:0] full_mask;
   logic [TOTAL_W-1:0]       new_total;
   logic [IDX_W-1:0]         target_idx;
   logic                     complete;

   frt_entry_table #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   frt_cmp_unit u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   assign chunk_eff = (chunk_len_ff > LEN_W'(CHUNK_MAX)) ? LEN_W'(CHUNK_MAX) : chunk_len_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_total_ff, rsp_offset_ff, rsp_slot_ff};

   assign scan_done = pend_ff && (pend_idx_ff == LAST_IDX);

   // shared compare: id match in lookup, stamp + timeout in sweep
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         cmp_req.op_a = now_ff;
         cmp_req.op_b = tbl_rd_data.stamp;
         cmp_req.op_c = timeout_ff;
      end else begin
         cmp_req.op_a = TIME_W'(id_ff);
         cmp_req.op_b = TIME_W'(tbl_rd_data.packet_id);
         cmp_req.op_c = '0;
      end
   end

   always_comb begin
      bad_frag  = (32'(last_ff) >= MAX_FRAGMENTS) || (seq_ff > last_ff) ||
                  ((seq_ff != last_ff) && (len_ff != chunk_eff));
      conflict  = hit_ff && ((hit_entry_ff.last_index != last_ff) ||
                             hit_entry_ff.mask[seq_ff]);
      new_mask  = (hit_ff ? hit_entry_ff.mask : '0) |
                  (MAX_FRAGMENTS'(1) << seq_ff);
      full_mask = {MAX_FRAGMENTS{1'b1}} >> (SEQ_W'(MAX_FRAGMENTS - 1) - last_ff);
      if (seq_ff == last_ff) begin
         new_total = TOTAL_W'(offset_ff) + TOTAL_W'(len_ff);
      end else begin
         new_total = hit_ff ? hit_entry_ff.total_len : '0;
      end
      target_idx = hit_ff ? hit_idx_ff : free_idx_ff;
      complete   = (new_mask == full_mask);
   end

   always_comb begin
      state_in      = state_ff;
      chunk_len_in  = chunk_len_ff;
      timeout_in    = timeout_ff;
      id_in         = id_ff;
      seq_in        = seq_ff;
      last_in       = last_ff;
      len_in        = len_ff;
      now_in        = now_ff;
      offset_in     = offset_ff;
      valid_in      = valid_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_offset_in = res_offset_ff;
      res_total_in  = res_total_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_total_in  = rsp_total_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = target_idx;
      tbl_wr_data   = '{packet_id: id_ff, last_index: last_ff, mask: new_mask,
                        stamp: now_ff, total_len: new_total};
      tbl_rd_addr   = scan_idx_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_CHUNK_LEN: chunk_len_in = csr_wdata[LEN_W-1:0];
            CSR_TIMEOUT:   timeout_in   = csr_wdata[TMO_W-1:0];
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if ((state_ff == ST_LOOKUP || state_ff == ST_SWEEP) && issue_ff) begin
         pend_in     = 1'b1;
         pend_idx_in = scan_idx_ff;
         if (scan_idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               id_in    = req_tdata[15:0];
               seq_in   = req_tdata[19:16];
               last_in  = req_tdata[23:20];
               len_in   = req_tdata[34:24];
               now_in   = req_tdata[66:35];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            offset_in   = OFFSET_W'(seq_ff) * OFFSET_W'(chunk_eff);
            hit_in      = 1'b0;
            free_in     = 1'b0;
            scan_idx_in = '0;
            issue_in    = 1'b1;
            if (len_ff == '0 || len_ff > chunk_eff) begin
               res_status_in = STATUS_DROP;
               res_slot_in   = '0;
               res_offset_in = '0;
               res_total_in  = '0;
               issue_in      = 1'b0;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (pend_ff) begin
               if (valid_ff[pend_idx_ff]) begin
                  if (!hit_ff && cmp_rsp.eq) begin
                     hit_in       = 1'b1;
                     hit_idx_in   = pend_idx_ff;
                     hit_entry_in = tbl_rd_data;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
            end
            if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_offset_in = '0;
            res_total_in  = '0;
            res_slot_in   = hit_ff ? SLOT_W'(hit_idx_ff) : '0;
            if (bad_frag || conflict) begin
               res_status_in = STATUS_REJECT;
            end else if (!hit_ff && !free_ff) begin
               res_status_in = STATUS_FULL;
            end else begin
               tbl_wr_en              = 1'b1;
               valid_in[target_idx]   = !complete;
               res_slot_in            = SLOT_W'(target_idx);
               res_offset_in          = offset_ff;
               if (complete) begin
                  res_status_in = STATUS_COMPLETE;
                  res_total_in  = new_total;
               end else begin
                  res_status_in = STATUS_ACCEPT;
               end
            end
            scan_idx_in = '0;
            issue_in    = 1'b1;
            state_in    = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (pend_ff && valid_ff[pend_idx_ff] && cmp_rsp.gt) begin
               valid_in[pend_idx_ff] = 1'b0;
            end
            if (scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_offset_in = res_offset_ff;
               rsp_total_in  = res_total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chunk_len_ff  <= LEN_W'(1024);
         timeout_ff    <= TMO_W'(30);
         valid_ff      <= '0;
         issue_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chunk_len_ff  <= chunk_len_in;
         timeout_ff    <= timeout_in;
         valid_ff      <= valid_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      seq_ff        <= seq_in;
      last_ff       <= last_in;
      len_ff        <= len_in;
      now_ff        <= now_in;
      offset_ff     <= offset_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_offset_ff <= res_offset_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

### sv/frt_cmp_unit.sv
module frt_cmp_unit
   import frt_pkg::*;
(
   input  cmp_req_type cmp_req,
   output cmp_rsp_type cmp_rsp
);

   logic [TIME_W:0] sum;
   logic [TIME_W:0] lhs;

   // a against b + c, no wrap
   assign sum = {1'b0, cmp_req.op_b} + (TIME_W+1)'(cmp_req.op_c);
   assign lhs = {1'b0, cmp_req.op_a};

   assign cmp_rsp.eq = (lhs == sum);
   assign cmp_rsp.gt = (lhs > sum);

endmodule

### sv/frt_entry_table.sv
module frt_entry_table
   import frt_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT,
   parameter int IDX_W       = 4
)
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [NUM_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
